// File: hw/rtl/pat_pkg.sv
// Shared types and constants for the positional array table.
// Holds the item codes, the cell select code and the fixed field widths.
// No dependencies.
package pat_pkg;

	localparam int WORD_W    = 32;
	localparam int POS_W     = 7;
	localparam int FIDX_W    = 7;
	localparam int FILL_W    = 8;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_BAD_POS   = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CM_HOLD  = 2'd0,
		CM_LEFT  = 2'd1,
		CM_RIGHT = 2'd2,
		CM_LOAD  = 2'd3
	} cell_mode_t;

endpackage

// File: hw/rtl/pat_cell.sv
// One storage cell of the table chain: a 32-bit entry with a neighbour select.
// Depends on pat_pkg for the word and select types.
module pat_cell (
	input  logic                clk,
	input  pat_pkg::cell_mode_t mode,
	input  pat_pkg::word_t      left_val,
	input  pat_pkg::word_t      right_val,
	input  pat_pkg::word_t      load_val,
	output pat_pkg::word_t      val
);
	import pat_pkg::*;

	word_t val_q;

	always_ff @(posedge clk) begin
		case (mode)
			CM_LEFT:  val_q <= left_val;
			CM_RIGHT: val_q <= right_val;
			CM_LOAD:  val_q <= load_val;
			default:  val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// File: hw/rtl/positional_array_table.sv
// Top level of the positional array table: chain of entry cells plus sequencer.
// Depends on pat_pkg and pat_cell.
//
// Usage
//   Input items arrive on s_t*: s_tuser carries the command (insert, delete,
//   search, read), s_tdata the value and the position. Each item yields one
//   result item on m_t*: m_tuser carries the status, m_tdata the found index,
//   the read value and the fill count after the command.
//   Insert and delete shift the cells from the position onward towards their
//   neighbours in a single edge, so these items (and any rejected item) finish
//   in their accept cycle and a new one may follow while the result stage can
//   move on; the result passes the result stage and then the output register.
//   Search of a non-empty table and read of a valid position rotate the whole
//   chain once past cell 0, one entry per cycle, where the compare and capture
//   are done: such an item holds the block for its accept cycle and a rotation
//   as long as the chain, and its result then passes the result stage and the
//   output register.
//   A result stage sits between the chain and the output register, so one
//   further item is accepted while a result waits on a stalled receiver; after
//   that s_tready drops until m_tready frees the output. A finished rotation
//   waits in place while the result stage is still full.
//   Reset empties the table (fill count zero) and clears both valid flags;
//   entry contents are left as they are and are never read before written.
module positional_array_table #(
	parameter int CAPACITY = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] item_value, [38:32] position, [39] zero
	input  logic [pat_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] command
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [6:0] found_index, [38:7] read_value, [46:39] fill_count, [47] zero
	output logic [pat_pkg::M_TDATA_W-1:0]   m_tdata,
	// [1:0] status
	output logic [1:0]                      m_tuser
);
	import pat_pkg::*;

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);
	// compare width wide enough for both the position field and the count
	localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t                state_q;
	logic [CNTW-1:0]       count_q;
	logic [IDXW-1:0]       k_q;
	logic                  hit_q;
	logic [IDXW-1:0]       hit_idx_q;
	word_t                 rd_q;
	word_t                 key_q;
	logic [POS_W-1:0]      pos_q;
	cmd_t                  cmd_q;

	logic                  res_pend_q;
	status_t               res_status_q;
	logic [FIDX_W-1:0]     res_fidx_q;
	word_t                 res_rd_q;
	logic [FILL_W-1:0]     res_fill_q;

	logic                  m_tvalid_q;
	status_t               m_status_q;
	logic [FIDX_W-1:0]     m_fidx_q;
	word_t                 m_rd_q;
	logic [FILL_W-1:0]     m_fill_q;

	// input decode
	cmd_t                  in_cmd;
	word_t                 in_val;
	logic [POS_W-1:0]      in_pos;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       cnt_x;
	logic                  acc;
	logic                  full;
	logic                  ins_ok;
	logic                  del_ok;
	logic                  need_scan;
	status_t               imm_status;
	logic [CNTW-1:0]       imm_count;

	// scan decode
	word_t                 head;
	logic                  last_k;
	logic                  move;
	logic                  scan_stall;
	logic                  rotate;
	logic                  hit_now;
	logic                  rd_now;
	logic                  hit_fin;
	logic [IDXW-1:0]       idx_fin;
	logic                  res_load;

	word_t                 cell_val [CAPACITY];
	cell_mode_t            cell_mode [CAPACITY];

	assign in_cmd = cmd_t'(s_tuser);
	assign in_val = s_tdata[WORD_W-1:0];
	assign in_pos = s_tdata[WORD_W+POS_W-1:WORD_W];
	assign pos_x  = CMPW'(in_pos);
	assign cnt_x  = CMPW'(count_q);

	// result stage frees when it moves into the output register
	assign move     = res_pend_q && (!m_tvalid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE) && (!res_pend_q || move);
	assign acc      = s_tvalid && s_tready;

	assign full   = (count_q == CNTW'(CAPACITY));
	assign ins_ok = (in_cmd == CMD_INSERT) && !full && (pos_x <= cnt_x);
	assign del_ok = (in_cmd == CMD_DELETE) && (pos_x < cnt_x);
	assign need_scan = ((in_cmd == CMD_SEARCH) && (count_q != '0)) ||
	                   ((in_cmd == CMD_READ) && (pos_x < cnt_x));

	// result of an item that finishes in its accept cycle
	always_comb begin
		imm_status = STS_OK;
		imm_count  = count_q;
		case (in_cmd)
			CMD_INSERT: begin
				if (full)
					imm_status = STS_FULL;
				else if (!ins_ok)
					imm_status = STS_BAD_POS;
				else
					imm_count = count_q + CNTW'(1);
			end
			CMD_DELETE: begin
				if (!del_ok)
					imm_status = STS_BAD_POS;
				else
					imm_count = count_q - CNTW'(1);
			end
			CMD_SEARCH: imm_status = STS_NOT_FOUND;
			CMD_READ:   imm_status = STS_BAD_POS;
			default:    imm_status = STS_OK;
		endcase
	end

	// rotation scan: cell 0 shows entry k while the step counter k_q equals k
	assign head       = cell_val[0];
	assign last_k     = (k_q == IDXW'(CAPACITY - 1));
	assign scan_stall = last_k && res_pend_q && !move;
	assign rotate     = (state_q == ST_SCAN) && !scan_stall;
	assign hit_now    = (cmd_q == CMD_SEARCH) && !hit_q && (CMPW'(k_q) < cnt_x) &&
	                    (head == key_q);
	assign rd_now     = (cmd_q == CMD_READ) && (CMPW'(k_q) == CMPW'(pos_q));
	assign hit_fin    = hit_q || hit_now;
	assign idx_fin    = hit_q ? hit_idx_q : k_q;

	// a new result enters the result stage at this edge
	assign res_load   = ((state_q == ST_IDLE) && acc && !need_scan) || (rotate && last_k);

	// chain of cells: per-cell select from the shared command and its own index
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMPW-1:0] CELL_IDX = CMPW'(i);
		word_t left_v;
		word_t right_v;

		if (i == 0) begin : g_first
			assign left_v = in_val;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end

		// the last cell closes the ring for the rotation scan
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[0];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		always_comb begin
			cell_mode[i] = CM_HOLD;
			if (rotate)
				cell_mode[i] = CM_RIGHT;
			else if (acc && ins_ok) begin
				if (CELL_IDX > pos_x)
					cell_mode[i] = CM_LEFT;
				else if (CELL_IDX == pos_x)
					cell_mode[i] = CM_LOAD;
			end else if (acc && del_ok) begin
				if (CELL_IDX >= pos_x)
					cell_mode[i] = CM_RIGHT;
			end
		end

		pat_cell u_cell (
			.clk       (clk),
			.mode      (cell_mode[i]),
			.left_val  (left_v),
			.right_val (right_v),
			.load_val  (in_val),
			.val       (cell_val[i])
		);
	end

	// sequencer, fill count, result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			k_q          <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			rd_q         <= '0;
			key_q        <= '0;
			pos_q        <= '0;
			cmd_q        <= CMD_INSERT;
			res_pend_q   <= 1'b0;
			res_status_q <= STS_OK;
			res_fidx_q   <= '0;
			res_rd_q     <= '0;
			res_fill_q   <= '0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= STS_OK;
			m_fidx_q     <= '0;
			m_rd_q       <= '0;
			m_fill_q     <= '0;
		end else begin
			// output register: load from the result stage, drop when taken
			if (move) begin
				m_tvalid_q <= 1'b1;
				m_status_q <= res_status_q;
				m_fidx_q   <= res_fidx_q;
				m_rd_q     <= res_rd_q;
				m_fill_q   <= res_fill_q;
				if (!res_load)
					res_pend_q <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (need_scan) begin
							state_q   <= ST_SCAN;
							k_q       <= '0;
							hit_q     <= 1'b0;
							hit_idx_q <= '0;
							rd_q      <= '0;
							key_q     <= in_val;
							pos_q     <= in_pos;
							cmd_q     <= in_cmd;
						end else begin
							count_q      <= imm_count;
							res_pend_q   <= 1'b1;
							res_status_q <= imm_status;
							res_fidx_q   <= '0;
							res_rd_q     <= '0;
							res_fill_q   <= FILL_W'(imm_count);
						end
					end
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (hit_now) begin
							hit_q     <= 1'b1;
							hit_idx_q <= k_q;
						end
						if (rd_now)
							rd_q <= head;
						k_q <= k_q + IDXW'(1);
						if (last_k) begin
							// ring is back in order: hand over the result
							state_q      <= ST_IDLE;
							res_pend_q   <= 1'b1;
							res_fill_q   <= FILL_W'(count_q);
							res_rd_q     <= rd_now ? head : rd_q;
							res_fidx_q   <= (cmd_q == CMD_SEARCH && hit_fin) ?
							                FIDX_W'(idx_fin) : '0;
							res_status_q <= (cmd_q == CMD_SEARCH && !hit_fin) ?
							                STS_NOT_FOUND : STS_OK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {1'b0, m_fill_q, m_rd_q, m_fidx_q};

endmodule
